/* src/hrbp_pkg.sv */
`timescale 1ns / 1ps

package hrbp_pkg;

  typedef logic [1:0] status_t;
  typedef logic [2:0] class_t;

  localparam status_t RES_MORE = 2'd0;
  localparam status_t RES_GOOD = 2'd1;
  localparam status_t RES_BAD  = 2'd2;

  localparam class_t CL_NONE    = 3'd0;
  localparam class_t CL_METHOD  = 3'd1;
  localparam class_t CL_URI     = 3'd2;
  localparam class_t CL_NEWNAME = 3'd3;
  localparam class_t CL_NAME    = 3'd4;
  localparam class_t CL_VALUE   = 3'd5;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CTL_MAX = 8'h1F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] ACC_MAX  = 8'hFF;

  function automatic logic ctl_byte(input logic [7:0] b);
    return (b <= CH_CTL_MAX) || (b == CH_DEL);
  endfunction

  function automatic logic separator_byte(input logic [7:0] b);
    logic sep;
    sep = 1'b0;
    case (b) inside
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return sep;
  endfunction

  function automatic logic token_byte(input logic [7:0] b);
    return !b[7] && !ctl_byte(b) && !separator_byte(b);
  endfunction

  function automatic logic digit_byte(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // acc * 10 + digit, saturating at the top of the byte range
  function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] b);
    logic [11:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, b[3:0]};
    return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[7:0];
  endfunction

endpackage

/* src/hrbp_byte_if.sv */
`timescale 1ns / 1ps

interface hrbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

/* src/hrbp_result_if.sv */
`timescale 1ns / 1ps

interface hrbp_result_if;
  logic             valid;
  logic             ready;
  hrbp_pkg::status_t parse_status;
  hrbp_pkg::class_t  byte_class;
  logic [7:0]       byte_echo;
  logic [7:0]       version_major;
  logic [7:0]       version_minor;

  modport source (output valid, output parse_status, output byte_class, output byte_echo,
                  output version_major, output version_minor, input ready);
  modport sink (input valid, input parse_status, input byte_class, input byte_echo,
                input version_major, input version_minor, output ready);
endinterface

/* src/http_request_byte_parser.sv */
`timescale 1ns / 1ps
// An accepted byte goes through the input register, then the result register, to its result.
// Throughput: one byte per cycle while results are taken; the grammar step is combinational
// between the input register and the result register, and a held result can stall new bytes.
// Reset (rst, synchronous, active high): empty both stages, parser to method start,
// header flag and version accumulators to zero.
module http_request_byte_parser (
  input  logic                 clk,
  input  logic                 rst,
  hrbp_byte_if.sink            request,
  hrbp_result_if.source        result
);
  import hrbp_pkg::*;

  // Grammar states
  localparam logic [4:0] S_METHOD_START = 5'd0;
  localparam logic [4:0] S_METHOD       = 5'd1;
  localparam logic [4:0] S_URI          = 5'd2;
  localparam logic [4:0] S_VER_H        = 5'd3;
  localparam logic [4:0] S_VER_T1       = 5'd4;
  localparam logic [4:0] S_VER_T2       = 5'd5;
  localparam logic [4:0] S_VER_P        = 5'd6;
  localparam logic [4:0] S_VER_SLASH    = 5'd7;
  localparam logic [4:0] S_MAJOR_START  = 5'd8;
  localparam logic [4:0] S_MAJOR        = 5'd9;
  localparam logic [4:0] S_MINOR_START  = 5'd10;
  localparam logic [4:0] S_MINOR        = 5'd11;
  localparam logic [4:0] S_NL1          = 5'd12;
  localparam logic [4:0] S_LINE_START   = 5'd13;
  localparam logic [4:0] S_LWS          = 5'd14;
  localparam logic [4:0] S_NAME         = 5'd15;
  localparam logic [4:0] S_SPACE_VALUE  = 5'd16;
  localparam logic [4:0] S_VALUE        = 5'd17;
  localparam logic [4:0] S_NL2          = 5'd18;
  localparam logic [4:0] S_NL3          = 5'd19;

  // Input register stage
  logic       in_valid;
  logic [7:0] in_byte;

  // Result register stage
  logic       out_valid;
  status_t    out_status;
  class_t     out_class;
  logic [7:0] out_echo;
  logic [7:0] out_major;
  logic [7:0] out_minor;

  // Parser state
  logic [4:0] state;
  logic       seen_header;
  logic [7:0] major_acc;
  logic [7:0] minor_acc;

  logic [4:0] state_next;
  logic       seen_header_next;
  logic [7:0] major_acc_next;
  logic [7:0] minor_acc_next;
  status_t    status_next;
  class_t     class_next;

  logic advance;  // result register can take a new result this cycle
  logic step;     // the held byte moves through the grammar this cycle

  assign advance       = !out_valid || result.ready;
  assign step          = in_valid && advance;
  // Take a new byte whenever the input register empties or moves on this cycle.
  assign request.ready = !in_valid || advance;

  assign result.valid         = out_valid;
  assign result.parse_status  = out_status;
  assign result.byte_class    = out_class;
  assign result.byte_echo     = out_echo;
  assign result.version_major = out_major;
  assign result.version_minor = out_minor;

  // One grammar step on the held byte.
  always_comb begin
    state_next       = state;
    seen_header_next = seen_header;
    major_acc_next   = major_acc;
    minor_acc_next   = minor_acc;
    status_next      = RES_MORE;
    class_next       = CL_NONE;
    unique case (state)
      S_METHOD_START: begin
        if (token_byte(in_byte)) begin
          state_next = S_METHOD;
          class_next = CL_METHOD;
        end else begin
          status_next = RES_BAD;
        end
      end
      S_METHOD: begin
        if (in_byte == CH_SP) state_next = S_URI;
        else if (token_byte(in_byte)) class_next = CL_METHOD;
        else status_next = RES_BAD;
      end
      S_URI: begin
        // Bytes at 128 and up pass as URI characters.
        if (in_byte == CH_SP) state_next = S_VER_H;
        else if (ctl_byte(in_byte)) status_next = RES_BAD;
        else class_next = CL_URI;
      end
      S_VER_H: begin
        if (in_byte == CH_H) state_next = S_VER_T1;
        else status_next = RES_BAD;
      end
      S_VER_T1: begin
        if (in_byte == CH_T) state_next = S_VER_T2;
        else status_next = RES_BAD;
      end
      S_VER_T2: begin
        if (in_byte == CH_T) state_next = S_VER_P;
        else status_next = RES_BAD;
      end
      S_VER_P: begin
        if (in_byte == CH_P) state_next = S_VER_SLASH;
        else status_next = RES_BAD;
      end
      S_VER_SLASH: begin
        if (in_byte == CH_SLASH) begin
          major_acc_next = '0;
          minor_acc_next = '0;
          state_next     = S_MAJOR_START;
        end else begin
          status_next = RES_BAD;
        end
      end
      S_MAJOR_START: begin
        if (digit_byte(in_byte)) begin
          major_acc_next = acc_digit(major_acc, in_byte);
          state_next     = S_MAJOR;
        end else begin
          status_next = RES_BAD;
        end
      end
      S_MAJOR: begin
        if (in_byte == CH_DOT) state_next = S_MINOR_START;
        else if (digit_byte(in_byte)) major_acc_next = acc_digit(major_acc, in_byte);
        else status_next = RES_BAD;
      end
      S_MINOR_START: begin
        if (digit_byte(in_byte)) begin
          minor_acc_next = acc_digit(minor_acc, in_byte);
          state_next     = S_MINOR;
        end else begin
          status_next = RES_BAD;
        end
      end
      S_MINOR: begin
        if (in_byte == CH_CR) state_next = S_NL1;
        else if (digit_byte(in_byte)) minor_acc_next = acc_digit(minor_acc, in_byte);
        else status_next = RES_BAD;
      end
      S_NL1: begin
        if (in_byte == CH_LF) state_next = S_LINE_START;
        else status_next = RES_BAD;
      end
      S_LINE_START: begin
        // Leading whitespace continues the previous header only once one exists.
        if (in_byte == CH_CR) begin
          state_next = S_NL3;
        end else if (seen_header && (in_byte == CH_SP || in_byte == CH_TAB)) begin
          state_next = S_LWS;
        end else if (token_byte(in_byte)) begin
          seen_header_next = 1'b1;
          class_next       = CL_NEWNAME;
          state_next       = S_NAME;
        end else begin
          status_next = RES_BAD;
        end
      end
      S_LWS: begin
        // Drop folded whitespace; the first other printable byte opens the value.
        if (in_byte == CH_CR) begin
          state_next = S_NL2;
        end else if (in_byte == CH_SP || in_byte == CH_TAB) begin
          state_next = S_LWS;
        end else if (ctl_byte(in_byte)) begin
          status_next = RES_BAD;
        end else begin
          class_next = CL_VALUE;
          state_next = S_VALUE;
        end
      end
      S_NAME: begin
        if (in_byte == CH_COLON) state_next = S_SPACE_VALUE;
        else if (token_byte(in_byte)) class_next = CL_NAME;
        else status_next = RES_BAD;
      end
      S_SPACE_VALUE: begin
        if (in_byte == CH_SP) state_next = S_VALUE;
        else status_next = RES_BAD;
      end
      S_VALUE: begin
        if (in_byte == CH_CR) state_next = S_NL2;
        else if (ctl_byte(in_byte)) status_next = RES_BAD;
        else class_next = CL_VALUE;
      end
      S_NL2: begin
        if (in_byte == CH_LF) state_next = S_LINE_START;
        else status_next = RES_BAD;
      end
      S_NL3: begin
        status_next = (in_byte == CH_LF) ? RES_GOOD : RES_BAD;
      end
      default: begin
        status_next = RES_BAD;
      end
    endcase
  end

  // Input stage: hold the byte until the result stage can take its outcome.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (request.ready) begin
      in_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.ready && request.valid) begin
      in_byte <= request.data_byte;
    end
  end

  // Parser state: restart from method start after a good or bad verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_METHOD_START;
      seen_header <= 1'b0;
      major_acc   <= '0;
      minor_acc   <= '0;
    end else if (step) begin
      if (status_next != RES_MORE) begin
        state       <= S_METHOD_START;
        seen_header <= 1'b0;
        major_acc   <= '0;
        minor_acc   <= '0;
      end else begin
        state       <= state_next;
        seen_header <= seen_header_next;
        major_acc   <= major_acc_next;
        minor_acc   <= minor_acc_next;
      end
    end
  end

  // Result stage: hold a result until its transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_status <= status_next;
      out_class  <= class_next;
      out_echo   <= in_byte;
      // Report the accumulators as updated by this byte, before any restart.
      out_major  <= major_acc_next;
      out_minor  <= minor_acc_next;
    end
  end

  // A verdict always sends the parser back to a clean start.
  assert property (@(posedge clk) disable iff (rst)
    step && (status_next != RES_MORE) |=>
      (state == S_METHOD_START) && !seen_header && (major_acc == '0) && (minor_acc == '0))
    else $error("parser did not restart after a verdict");

  // A tagged byte never carries a verdict.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_class == CL_NONE) || (out_status == RES_MORE))
    else $error("byte class set on a good or bad result");

  // The grammar never leaves its twenty states.
  assert property (@(posedge clk) disable iff (rst) state <= S_NL3)
    else $error("parser state out of range");

  // A held byte survives a stalled result stage.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("held byte lost while result stage stalled");

endmodule

/* sim/http_request_byte_parser_test.sv */
`timescale 1ns / 1ps

// Byte-stream checker for the HTTP request parser. Bytes go in one transaction
// at a time; every accepted byte is run through a local model of the request
// grammar and its expected result, or a FIXED row's hand-typed one, is queued. Each
// result transaction is compared field by field against the oldest queued entry.
module http_request_byte_parser_test;
  import hrbp_pkg::*;

  localparam int RANDOM_ITEMS   = 1800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_PRINTED    = 40;
  localparam bit FREE  = 1'b0;
  localparam bit FIXED = 1'b1;

  // Grammar positions of the local parser model.
  typedef enum logic [4:0] {
    P_METHOD_START, P_METHOD, P_URI, P_VER_H, P_VER_T1, P_VER_T2, P_VER_P,
    P_VER_SLASH, P_MAJOR_START, P_MAJOR, P_MINOR_START, P_MINOR, P_NL1,
    P_LINE_START, P_LWS, P_NAME, P_SPACE_VALUE, P_VALUE, P_NL2, P_NL3
  } grammar_pos_t;

  typedef struct packed {
    status_t    parse_status;
    class_t     byte_class;
    logic [7:0] byte_echo;
    logic [7:0] version_major;
    logic [7:0] version_minor;
  } parse_result_t;

  // One row of the directed table: the byte, and for FIXED rows the result
  // typed in by hand (echo is always the byte itself).
  typedef struct {
    logic [7:0] b;
    bit         fixed;
    status_t    st;
    class_t     cls;
    logic [7:0] maj;
    logic [7:0] mnr;
  } stim_row_t;

  logic clk;
  logic rst;

  hrbp_byte_if   req_if ();
  hrbp_result_if res_if ();

  http_request_byte_parser uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  // Model state.
  grammar_pos_t grammar_pos    = P_METHOD_START;
  bit           header_started = 1'b0;
  logic [7:0]   major_sum      = '0;
  logic [7:0]   minor_sum      = '0;

  parse_result_t expected_results[$];
  stim_row_t     stim_rows[$];
  logic [7:0]    frame[$];

  // Hand-typed expectation that travels with the byte currently presented.
  bit            use_fixed;
  parse_result_t fixed_result;

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  stall_cycles   = 0;
  int  sink_hold      = 0;
  bit  quiet;
  wire byte_taken   = req_if.valid && req_if.ready;
  wire result_taken = res_if.valid && res_if.ready;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Character classes of the request grammar.
  function automatic bit is_control(input logic [7:0] b);
    return (b <= CH_CTL_MAX) || (b == CH_DEL);
  endfunction

  function automatic bit is_delim(input logic [7:0] b);
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", CH_SP, CH_TAB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_token_char(input logic [7:0] b);
    return (b < 8'h80) && !is_control(b) && !is_delim(b);
  endfunction

  function automatic bit is_dec_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Append one decimal digit to a version number, clamping at the byte limit.
  function automatic logic [7:0] push_digit(input logic [7:0] acc, input logic [7:0] d);
    int v;
    v = int'(acc) * 10 + int'(d) - int'(CH_ZERO);
    return (v > int'(ACC_MAX)) ? ACC_MAX : v[7:0];
  endfunction

  // Advance the model by one byte and return the result it must produce.
  function automatic parse_result_t step_parser(input logic [7:0] b);
    parse_result_t r;
    grammar_pos_t  nxt;
    r.parse_status = RES_MORE;
    r.byte_class   = CL_NONE;
    nxt            = grammar_pos;
    case (grammar_pos)
      P_METHOD_START: begin
        if (is_token_char(b)) begin
          nxt          = P_METHOD;
          r.byte_class = CL_METHOD;
        end else r.parse_status = RES_BAD;
      end
      P_METHOD: begin
        if (b == CH_SP) nxt = P_URI;
        else if (is_token_char(b)) r.byte_class = CL_METHOD;
        else r.parse_status = RES_BAD;
      end
      P_URI: begin
        if (b == CH_SP) nxt = P_VER_H;
        else if (is_control(b)) r.parse_status = RES_BAD;
        else r.byte_class = CL_URI;
      end
      P_VER_H:  if (b == CH_H) nxt = P_VER_T1; else r.parse_status = RES_BAD;
      P_VER_T1: if (b == CH_T) nxt = P_VER_T2; else r.parse_status = RES_BAD;
      P_VER_T2: if (b == CH_T) nxt = P_VER_P; else r.parse_status = RES_BAD;
      P_VER_P:  if (b == CH_P) nxt = P_VER_SLASH; else r.parse_status = RES_BAD;
      P_VER_SLASH: begin
        // the slash restarts both version numbers
        if (b == CH_SLASH) begin
          major_sum = '0;
          minor_sum = '0;
          nxt       = P_MAJOR_START;
        end else r.parse_status = RES_BAD;
      end
      P_MAJOR_START: begin
        if (is_dec_digit(b)) begin
          major_sum = push_digit(major_sum, b);
          nxt       = P_MAJOR;
        end else r.parse_status = RES_BAD;
      end
      P_MAJOR: begin
        if (b == CH_DOT) nxt = P_MINOR_START;
        else if (is_dec_digit(b)) major_sum = push_digit(major_sum, b);
        else r.parse_status = RES_BAD;
      end
      P_MINOR_START: begin
        if (is_dec_digit(b)) begin
          minor_sum = push_digit(minor_sum, b);
          nxt       = P_MINOR;
        end else r.parse_status = RES_BAD;
      end
      P_MINOR: begin
        if (b == CH_CR) nxt = P_NL1;
        else if (is_dec_digit(b)) minor_sum = push_digit(minor_sum, b);
        else r.parse_status = RES_BAD;
      end
      P_NL1: if (b == CH_LF) nxt = P_LINE_START; else r.parse_status = RES_BAD;
      P_LINE_START: begin
        // leading blank continues the previous header, but only once one exists
        if (b == CH_CR) nxt = P_NL3;
        else if (header_started && (b == CH_SP || b == CH_TAB)) nxt = P_LWS;
        else if (is_token_char(b)) begin
          header_started = 1'b1;
          r.byte_class   = CL_NEWNAME;
          nxt            = P_NAME;
        end else r.parse_status = RES_BAD;
      end
      P_LWS: begin
        // drop further blanks of the continuation
        if (b == CH_CR) nxt = P_NL2;
        else if (b == CH_SP || b == CH_TAB) nxt = P_LWS;
        else if (is_control(b)) r.parse_status = RES_BAD;
        else begin
          r.byte_class = CL_VALUE;
          nxt          = P_VALUE;
        end
      end
      P_NAME: begin
        if (b == CH_COLON) nxt = P_SPACE_VALUE;
        else if (is_token_char(b)) r.byte_class = CL_NAME;
        else r.parse_status = RES_BAD;
      end
      P_SPACE_VALUE: if (b == CH_SP) nxt = P_VALUE; else r.parse_status = RES_BAD;
      P_VALUE: begin
        if (b == CH_CR) nxt = P_NL2;
        else if (is_control(b)) r.parse_status = RES_BAD;
        else r.byte_class = CL_VALUE;
      end
      P_NL2: if (b == CH_LF) nxt = P_LINE_START; else r.parse_status = RES_BAD;
      P_NL3: r.parse_status = (b == CH_LF) ? RES_GOOD : RES_BAD;
      default: r.parse_status = RES_BAD;
    endcase
    r.byte_echo     = b;
    r.version_major = major_sum;
    r.version_minor = minor_sum;
    // a finished or rejected request restarts the grammar from scratch
    if (r.parse_status != RES_MORE) begin
      grammar_pos    = P_METHOD_START;
      header_started = 1'b0;
      major_sum      = '0;
      minor_sum      = '0;
    end else grammar_pos = nxt;
    return r;
  endfunction

  // Idle length: usually a short gap, now and then a long stretch.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // Present one byte and hold it until the parser takes the transaction.
  // Valid stays high between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input bit fixed, input parse_result_t fres);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= b;
    use_fixed        <= fixed;
    fixed_result     <= fres;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Append one row to the directed table.
  task automatic add_row(input stim_row_t row);
    stim_rows = {stim_rows, row};
  endtask

  // Append one byte to the request being built.
  task automatic add_byte(input logic [7:0] b);
    frame = {frame, b};
  endtask

  // Frame builders for the random requests.
  task automatic add_tokens(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(33, 126)); while (!is_token_char(b));
      add_byte(b);
    end
  endtask

  task automatic add_text(input int n, input bit allow_space);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(32, 255)); while (is_control(b) || (!allow_space && b == CH_SP));
      add_byte(b);
    end
  endtask

  task automatic add_digits();
    int n;
    // an occasional long run can drive the version into saturation
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
    repeat (n) add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
  endtask

  task automatic add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  // Track the input side into the model and check the output side.
  always @(posedge clk) begin
    parse_result_t want;
    parse_result_t got;
    if (!rst) begin
      if (byte_taken) begin
        want = step_parser(req_if.data_byte);
        if (use_fixed) want = fixed_result;
        expected_results = {expected_results, want};
      end
      if (result_taken) begin
        got.parse_status  = res_if.parse_status;
        got.byte_class    = res_if.byte_class;
        got.byte_echo     = res_if.byte_echo;
        got.version_major = res_if.version_major;
        got.version_minor = res_if.version_minor;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte_echo %02h", got.byte_echo));
        end else begin
          want = expected_results.pop_front();
          if (got.parse_status !== want.parse_status)
            report_mismatch($sformatf("result %0d parse_status %0d, want %0d",
                                      results_seen, got.parse_status, want.parse_status));
          if (got.byte_class !== want.byte_class)
            report_mismatch($sformatf("result %0d byte_class %0d, want %0d",
                                      results_seen, got.byte_class, want.byte_class));
          if (got.byte_echo !== want.byte_echo)
            report_mismatch($sformatf("result %0d byte_echo %02h, want %02h",
                                      results_seen, got.byte_echo, want.byte_echo));
          if (got.version_major !== want.version_major)
            report_mismatch($sformatf("result %0d version_major %0d, want %0d",
                                      results_seen, got.version_major, want.version_major));
          if (got.version_minor !== want.version_minor)
            report_mismatch($sformatf("result %0d version_minor %0d, want %0d",
                                      results_seen, got.version_minor, want.version_minor));
        end
        results_seen++;
      end
    end
  end

  // Receiver back-pressure: random stalls unless a quiet stretch is running.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      res_if.ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      sink_hold     <= idle_len() - 1;
      res_if.ready  <= 1'b0;
    end else begin
      res_if.ready  <= 1'b1;
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if (rst || byte_taken || result_taken) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $realtime, stall_cycles);
      $display("http_request_byte_parser_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int sent;
    int n_headers;
    rst              <= 1'b1;
    req_if.valid     <= 1'b0;
    req_if.data_byte <= '0;
    use_fixed        <= 1'b0;
    fixed_result     <= '0;
    quiet            <= 1'b0;
    sent             = 0;

    // Directed table. FIXED rows carry a hand-typed result; FREE rows are
    // checked against the model.
    // right after reset a NUL or DEL cannot open a method
    add_row(stim_row_t'{8'h00, FIXED, RES_BAD, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_DEL, FIXED, RES_BAD, CL_NONE, 8'd0, 8'd0});
    // request line with a high byte in the URI and a saturating major version
    add_row(stim_row_t'{"G", FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_SP, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{8'hFF, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_SP, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_H, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_T, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_T, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_P, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_SLASH, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{"9", FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{"9", FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{"9", FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_DOT, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_ZERO, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_CR, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    add_row(stim_row_t'{CH_LF, FREE, RES_MORE, CL_NONE, 8'd0, 8'd0});
    // continuation blank before any header: rejected, version still visible
    add_row(stim_row_t'{CH_SP, FIXED, RES_BAD, CL_NONE, ACC_MAX, 8'd0});
    // the reject cleared everything, so a high byte is again a bad method start
    add_row(stim_row_t'{8'hFF, FIXED, RES_BAD, CL_NONE, 8'd0, 8'd0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      send_byte(stim_rows[i].b, stim_rows[i].fixed,
                parse_result_t'{stim_rows[i].st, stim_rows[i].cls, stim_rows[i].b,
                                stim_rows[i].maj, stim_rows[i].mnr});
    end
    // hold off until the directed part has fully come back
    wait_drained();

    // Random part: mostly well-formed requests with random content, some
    // with one corrupted byte, and a few bursts of pure noise.
    while (sent < RANDOM_ITEMS) begin
      frame.delete();
      quiet <= ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_tokens($urandom_range(1, 6));
        add_byte(CH_SP);
        add_text($urandom_range(0, 8), 1'b0);
        add_byte(CH_SP);
        add_byte(CH_H);
        add_byte(CH_T);
        add_byte(CH_T);
        add_byte(CH_P);
        add_byte(CH_SLASH);
        add_digits();
        add_byte(CH_DOT);
        add_digits();
        add_crlf();
        n_headers = $urandom_range(0, 3);
        repeat (n_headers) begin
          add_tokens($urandom_range(1, 6));
          add_byte(CH_COLON);
          add_byte(CH_SP);
          add_text($urandom_range(0, 8), 1'b1);
          add_crlf();
          // folded continuation line
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
            add_text($urandom_range(0, 6), 1'b1);
            add_crlf();
          end
        end
        add_crlf();
        // break one byte of the request now and then
        if ($urandom_range(0, 3) == 0)
          frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
      end
      foreach (frame[i]) send_byte(frame[i], 1'b0, '0);
      sent += frame.size();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("http_request_byte_parser_test: PASS");
    end else begin
      $display("http_request_byte_parser_test: FAIL");
    end
    $finish;
  end

endmodule
